### hdl/tampc_pkg.sv
// Package for the two-axis move power controller.
// Holds the sequencer state type, iterative unit command types, direction codes
// and configuration register indexes. No dependencies.
package tampc_pkg;

    typedef enum logic [4:0] {
        ST_IDLE,
        ST_DIST,
        ST_SQ_U,
        ST_SQ_V,
        ST_SUM,
        ST_CHECK,
        ST_ROOT,
        ST_MUL_U,
        ST_DIV_U,
        ST_WAIT_U,
        ST_MUL_V,
        ST_DIV_V,
        ST_WAIT_V,
        ST_ADJ1,
        ST_WAIT_Q1,
        ST_SCALE1,
        ST_APPLY1,
        ST_ADJ2,
        ST_WAIT_Q2,
        ST_SCALE2,
        ST_APPLY2,
        ST_FINAL,
        ST_OUT
    } seq_state_t;

    typedef enum logic {
        OP_SQRT,
        OP_DIV
    } iter_op_t;

    typedef struct packed {
        logic     start;
        iter_op_t op;
    } iter_cmd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } iter_status_t;

    // Direction codes: two's complement -1, 0, +1 in two bits.
    localparam logic [1:0] SGN_ZERO = 2'b00;
    localparam logic [1:0] SGN_POS  = 2'b01;
    localparam logic [1:0] SGN_NEG  = 2'b11;

    localparam logic [2:0] REG_MOVE_SPEED    = 3'd0;
    localparam logic [2:0] REG_FIRST_MIN     = 3'd1;
    localparam logic [2:0] REG_SECOND_MIN    = 3'd2;
    localparam logic [2:0] REG_FIRST_MAX     = 3'd3;
    localparam logic [2:0] REG_SECOND_MAX    = 3'd4;
    localparam logic [2:0] REG_STOP_DIST_SQ  = 3'd5;
    localparam logic [2:0] REG_KICK_POWER    = 3'd6;

    // Width of intermediate axis powers; rescaled values stay below 2^15.
    localparam int PWR_W = 16;

endpackage

### hdl/two_axis_move_power_control.sv
// Two-axis move power controller: top level, sequencer and configuration.
// A kick, or a tick while idle, goes straight to the output state; a transaction within the
// stop distance ends at the distance check, and any other one takes the square root, both
// divisions and each needed minimum rescale in turn on the shared unit.
// One transaction is processed at a time; s_ready is high only between items, and a
// result held by m_ready stalls the input. Synchronous reset restores defaults and idle.
module two_axis_move_power_control #(
    parameter int POSITION_BITS = 24,
    parameter int FRACTION_BITS = 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [2:0]                      cfg_index,
    input  logic [7:0]                      cfg_wr_data,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic                            s_start_move,
    input  logic signed [POSITION_BITS-1:0] s_target_first,
    input  logic signed [POSITION_BITS-1:0] s_target_second,
    input  logic signed [POSITION_BITS-1:0] s_count_first,
    input  logic signed [POSITION_BITS-1:0] s_count_second,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic signed [7:0]               m_drive_first,
    output logic signed [7:0]               m_drive_second,
    output logic                            m_kick,
    output logic                            m_finished
);
    import tampc_pkg::*;

    localparam int P   = POSITION_BITS;
    localparam int F   = FRACTION_BITS;
    localparam int MB  = (P > 7 + F) ? P : 7 + F;
    localparam int NW  = P + F + 7;
    localparam int DW  = P + F + 1;
    localparam int RW  = 2 * (P + F + 1);
    localparam int D2W = 2 * P + 1;

    // Configuration registers.
    logic [6:0] speed_reg, min1_reg, min2_reg, max1_reg, max2_reg, kickp_reg;
    logic [7:0] stop_reg;

    // Move state.
    logic [P-1:0] goal_f_reg, goal_s_reg;
    logic [1:0]   sgn_f_reg, sgn_s_reg, last_sgn_s_reg;
    logic         done_reg;

    // Datapath registers.
    seq_state_t       state_reg, state_next;
    logic [P-1:0]     cnt_f_reg, cnt_s_reg;
    logic [P-1:0]     du_reg, dv_reg;
    logic [D2W-1:0]   acc_reg;
    logic [P+MB-1:0]  prod_reg;
    logic [DW-1:0]    root_reg;
    logic [PWR_W-1:0] pu_reg, pv_reg;
    logic [F+6:0]     q_reg;
    logic [7:0]       rdf_reg, rds_reg;
    logic             rkick_reg, rfin_reg;

    // Output register.
    logic             m_valid_reg;
    logic [7:0]       m_df_reg, m_ds_reg;
    logic             m_kick_reg, m_fin_reg;

    // Shared unit.
    iter_cmd_t      ucmd;
    iter_status_t   ustat;
    logic [RW-1:0]  uopa;
    logic [DW-1:0]  uopb;
    logic [NW-1:0]  ures;

    logic [P-1:0]   mul_a;
    logic [MB-1:0]  mul_b;

    logic           accept;
    logic [P:0]     diff_f, diff_s, ndiff_f, ndiff_s;
    logic [P:0]     ndiff_fn, ndiff_sn;
    logic [1:0]     new_sgn_f, new_sgn_s;
    logic [P-1:0]   du_c, dv_c;
    logic [6:0]     mag_f, mag_s;

    assign accept  = s_valid && s_ready;
    assign s_ready = (state_reg == ST_IDLE);

    always_comb begin
        // Direction at a start, from the new targets and current counts.
        ndiff_fn  = {s_target_first[P-1], s_target_first} - {s_count_first[P-1], s_count_first};
        ndiff_sn  = {s_target_second[P-1], s_target_second}
                    - {s_count_second[P-1], s_count_second};
        new_sgn_f = ndiff_fn[P] ? SGN_NEG : ((ndiff_fn != '0) ? SGN_POS : SGN_ZERO);
        new_sgn_s = ndiff_sn[P] ? SGN_NEG : ((ndiff_sn != '0) ? SGN_POS : SGN_ZERO);

        // Remaining distances, clipped at zero once the target is passed.
        diff_f  = {goal_f_reg[P-1], goal_f_reg} - {cnt_f_reg[P-1], cnt_f_reg};
        diff_s  = {goal_s_reg[P-1], goal_s_reg} - {cnt_s_reg[P-1], cnt_s_reg};
        ndiff_f = -diff_f;
        ndiff_s = -diff_s;
        if (sgn_f_reg == SGN_POS && !diff_f[P]) begin
            du_c = diff_f[P-1:0];
        end else if (sgn_f_reg == SGN_NEG && diff_f[P]) begin
            du_c = ndiff_f[P-1:0];
        end else begin
            du_c = '0;
        end
        if (sgn_s_reg == SGN_POS && !diff_s[P]) begin
            dv_c = diff_s[P-1:0];
        end else if (sgn_s_reg == SGN_NEG && diff_s[P]) begin
            dv_c = ndiff_s[P-1:0];
        end else begin
            dv_c = '0;
        end

        mag_f = (pu_reg > PWR_W'(max1_reg)) ? max1_reg : pu_reg[6:0];
        mag_s = (pv_reg > PWR_W'(max2_reg)) ? max2_reg : pv_reg[6:0];
    end

    // Sequencer: next state, unit commands and multiplier operands.
    always_comb begin
        state_next = state_reg;
        ucmd.start = 1'b0;
        ucmd.op    = OP_DIV;
        uopa       = '0;
        uopb       = root_reg;
        mul_a      = du_reg;
        mul_b      = MB'(speed_reg);
        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    if (s_start_move && new_sgn_s != last_sgn_s_reg) begin
                        state_next = ST_OUT;
                    end else if (!s_start_move && done_reg) begin
                        state_next = ST_OUT;
                    end else begin
                        state_next = ST_DIST;
                    end
                end
            end
            ST_DIST: state_next = ST_SQ_U;
            ST_SQ_U: begin
                mul_a      = du_reg;
                mul_b      = MB'(du_reg);
                state_next = ST_SQ_V;
            end
            ST_SQ_V: begin
                mul_a      = dv_reg;
                mul_b      = MB'(dv_reg);
                state_next = ST_SUM;
            end
            ST_SUM:  state_next = ST_CHECK;
            ST_CHECK: begin
                if (acc_reg <= D2W'(stop_reg)) begin
                    state_next = ST_OUT;
                end else begin
                    ucmd.start = 1'b1;
                    ucmd.op    = OP_SQRT;
                    uopa       = RW'(acc_reg) << (2 * F);
                    state_next = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (ustat.done) begin
                    state_next = ST_MUL_U;
                end
            end
            ST_MUL_U: begin
                mul_a      = du_reg;
                mul_b      = MB'(speed_reg);
                state_next = ST_DIV_U;
            end
            ST_DIV_U: begin
                ucmd.start = 1'b1;
                uopa       = RW'(prod_reg[P+6:0]) << F;
                uopb       = root_reg;
                state_next = ST_WAIT_U;
            end
            ST_WAIT_U: begin
                if (ustat.done) begin
                    state_next = ST_MUL_V;
                end
            end
            ST_MUL_V: begin
                mul_a      = dv_reg;
                mul_b      = MB'(speed_reg);
                state_next = ST_DIV_V;
            end
            ST_DIV_V: begin
                ucmd.start = 1'b1;
                uopa       = RW'(prod_reg[P+6:0]) << F;
                uopb       = root_reg;
                state_next = ST_WAIT_V;
            end
            ST_WAIT_V: begin
                if (ustat.done) begin
                    state_next = ST_ADJ1;
                end
            end
            ST_ADJ1: begin
                if (pu_reg != '0 && pu_reg < PWR_W'(min1_reg)) begin
                    ucmd.start = 1'b1;
                    uopa       = RW'(min1_reg) << F;
                    uopb       = DW'(pu_reg);
                    state_next = ST_WAIT_Q1;
                end else begin
                    state_next = ST_ADJ2;
                end
            end
            ST_WAIT_Q1: begin
                if (ustat.done) begin
                    state_next = ST_SCALE1;
                end
            end
            ST_SCALE1: begin
                mul_a      = P'(pv_reg);
                mul_b      = MB'(q_reg);
                state_next = ST_APPLY1;
            end
            ST_APPLY1: state_next = ST_ADJ2;
            ST_ADJ2: begin
                if (pv_reg != '0 && pv_reg < PWR_W'(min2_reg)) begin
                    ucmd.start = 1'b1;
                    uopa       = RW'(min2_reg) << F;
                    uopb       = DW'(pv_reg);
                    state_next = ST_WAIT_Q2;
                end else begin
                    state_next = ST_FINAL;
                end
            end
            ST_WAIT_Q2: begin
                if (ustat.done) begin
                    state_next = ST_SCALE2;
                end
            end
            ST_SCALE2: begin
                mul_a      = P'(pu_reg);
                mul_b      = MB'(q_reg);
                state_next = ST_APPLY2;
            end
            ST_APPLY2: state_next = ST_FINAL;
            ST_FINAL:  state_next = ST_OUT;
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    // Configuration and move state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            speed_reg      <= 7'd15;
            min1_reg       <= 7'd10;
            min2_reg       <= 7'd5;
            max1_reg       <= 7'd20;
            max2_reg       <= 7'd20;
            stop_reg       <= 8'd2;
            kickp_reg      <= 7'd10;
            goal_f_reg     <= '0;
            goal_s_reg     <= '0;
            sgn_f_reg      <= SGN_ZERO;
            sgn_s_reg      <= SGN_ZERO;
            last_sgn_s_reg <= SGN_ZERO;
            done_reg       <= 1'b1;
        end else begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_MOVE_SPEED:   speed_reg <= cfg_wr_data[6:0];
                    REG_FIRST_MIN:    min1_reg  <= cfg_wr_data[6:0];
                    REG_SECOND_MIN:   min2_reg  <= cfg_wr_data[6:0];
                    REG_FIRST_MAX:    max1_reg  <= cfg_wr_data[6:0];
                    REG_SECOND_MAX:   max2_reg  <= cfg_wr_data[6:0];
                    REG_STOP_DIST_SQ: stop_reg  <= cfg_wr_data;
                    REG_KICK_POWER:   kickp_reg <= cfg_wr_data[6:0];
                    default: ;
                endcase
            end
            if (accept && s_start_move) begin
                goal_f_reg     <= s_target_first;
                goal_s_reg     <= s_target_second;
                sgn_f_reg      <= new_sgn_f;
                sgn_s_reg      <= new_sgn_s;
                last_sgn_s_reg <= new_sgn_s;
                done_reg       <= 1'b0;
            end
            if (state_reg == ST_CHECK && acc_reg <= D2W'(stop_reg)) begin
                done_reg <= 1'b1;
            end
        end
    end

    // Datapath and staged result.
    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        case (state_reg)
            ST_IDLE: begin
                cnt_f_reg <= s_count_first;
                cnt_s_reg <= s_count_second;
                rkick_reg <= 1'b0;
                rfin_reg  <= 1'b1;
                rdf_reg   <= '0;
                rds_reg   <= '0;
                if (s_start_move) begin
                    rkick_reg <= 1'b1;
                    rfin_reg  <= 1'b0;
                    case (new_sgn_s)
                        SGN_POS: rds_reg <= {1'b0, kickp_reg};
                        SGN_NEG: rds_reg <= -{1'b0, kickp_reg};
                        default: rds_reg <= '0;
                    endcase
                end
            end
            ST_DIST: begin
                du_reg <= du_c;
                dv_reg <= dv_c;
            end
            ST_SQ_V:  acc_reg <= D2W'(prod_reg);
            ST_SUM:   acc_reg <= acc_reg + D2W'(prod_reg);
            ST_CHECK: begin
                rkick_reg <= 1'b0;
                rfin_reg  <= 1'b1;
                rdf_reg   <= '0;
                rds_reg   <= '0;
            end
            ST_ROOT: begin
                if (ustat.done) begin
                    root_reg <= ures[DW-1:0];
                end
            end
            ST_WAIT_U: begin
                if (ustat.done) begin
                    pu_reg <= ures[PWR_W-1:0];
                end
            end
            ST_WAIT_V: begin
                if (ustat.done) begin
                    pv_reg <= ures[PWR_W-1:0];
                end
            end
            ST_WAIT_Q1, ST_WAIT_Q2: begin
                if (ustat.done) begin
                    q_reg <= ures[F+6:0];
                end
            end
            ST_APPLY1: begin
                pv_reg <= prod_reg[F+PWR_W-1:F];
                pu_reg <= PWR_W'(min1_reg);
            end
            ST_APPLY2: begin
                pu_reg <= prod_reg[F+PWR_W-1:F];
                pv_reg <= PWR_W'(min2_reg);
            end
            ST_FINAL: begin
                rkick_reg <= 1'b0;
                rfin_reg  <= 1'b0;
                case (sgn_f_reg)
                    SGN_POS: rdf_reg <= {1'b0, mag_f};
                    SGN_NEG: rdf_reg <= -{1'b0, mag_f};
                    default: rdf_reg <= '0;
                endcase
                case (sgn_s_reg)
                    SGN_POS: rds_reg <= {1'b0, mag_s};
                    SGN_NEG: rds_reg <= -{1'b0, mag_s};
                    default: rds_reg <= '0;
                endcase
            end
            default: ;
        endcase
    end

    // Output register: a finished result waits here until the transaction completes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (state_reg == ST_OUT && (!m_valid_reg || m_ready)) begin
            m_df_reg   <= rdf_reg;
            m_ds_reg   <= rds_reg;
            m_kick_reg <= rkick_reg;
            m_fin_reg  <= rfin_reg;
        end
    end

    tampc_iter #(
        .POSITION_BITS(POSITION_BITS),
        .FRACTION_BITS(FRACTION_BITS)
    ) u_iter (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (ucmd),
        .opa     (uopa),
        .opb     (uopb),
        .status  (ustat),
        .res     (ures)
    );

    assign m_valid        = m_valid_reg;
    assign m_drive_first  = m_df_reg;
    assign m_drive_second = m_ds_reg;
    assign m_kick         = m_kick_reg;
    assign m_finished     = m_fin_reg;

    a_kick_not_fin: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> !(m_kick_reg && m_fin_reg))
        else $error("kick result marked as finished");
    a_fin_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_fin_reg) |-> (m_df_reg == '0 && m_ds_reg == '0))
        else $error("finished result drives the motors");
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        accept |=> !s_ready)
        else $error("second transaction taken while one is in progress");
    a_unit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        ucmd.start |-> !ustat.busy)
        else $error("shared unit started while busy");

endmodule

### hdl/tampc_iter.sv
// Shared iterative unit: restoring square root (two radicand bits a step)
// and restoring division (one dividend bit a step) on one subtractor.
// Depends on tampc_pkg.
module tampc_iter #(
    parameter int POSITION_BITS = 24,
    parameter int FRACTION_BITS = 8
) (
    input  logic                                                 aclk,
    input  logic                                                 aresetn,
    input  tampc_pkg::iter_cmd_t                                 cmd,
    input  logic [2*(POSITION_BITS+FRACTION_BITS+1)-1:0]         opa,
    input  logic [POSITION_BITS+FRACTION_BITS:0]                 opb,
    output tampc_pkg::iter_status_t                              status,
    output logic [POSITION_BITS+FRACTION_BITS+6:0]               res
);
    import tampc_pkg::*;

    localparam int RW = 2 * (POSITION_BITS + FRACTION_BITS + 1);
    localparam int NW = POSITION_BITS + FRACTION_BITS + 7;
    localparam int DW = POSITION_BITS + FRACTION_BITS + 1;
    localparam int W  = POSITION_BITS + FRACTION_BITS + 4;
    localparam int CW = $clog2(NW + 1);

    logic           busy_reg;
    logic           done_reg;
    iter_op_t       op_reg;
    logic [CW-1:0]  cnt_reg;
    logic [RW-1:0]  src_reg;
    logic [W-1:0]   rem_reg;
    logic [NW-1:0]  res_reg;
    logic [DW-1:0]  dvs_reg;

    logic [W-1:0]   sub_a;
    logic [W-1:0]   sub_b;
    logic [W:0]     diff;
    logic           ge;

    always_comb begin
        if (op_reg == OP_SQRT) begin
            sub_a = {rem_reg[W-3:0], src_reg[RW-1 -: 2]};
            sub_b = {res_reg[W-3:0], 2'b01};
        end else begin
            sub_a = {rem_reg[W-2:0], src_reg[RW-1]};
            sub_b = W'(dvs_reg);
        end
        diff = {1'b0, sub_a} - {1'b0, sub_b};
        ge   = ~diff[W];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
            op_reg   <= OP_SQRT;
        end else begin
            done_reg <= 1'b0;
            if (cmd.start) begin
                busy_reg <= 1'b1;
                op_reg   <= cmd.op;
                cnt_reg  <= (cmd.op == OP_SQRT) ? CW'(DW) : CW'(NW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CW'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            src_reg <= (cmd.op == OP_SQRT) ? opa : (opa << (RW - NW));
            rem_reg <= '0;
            res_reg <= '0;
            dvs_reg <= opb;
        end else if (busy_reg) begin
            rem_reg <= ge ? diff[W-1:0] : sub_a;
            res_reg <= {res_reg[NW-2:0], ge};
            src_reg <= (op_reg == OP_SQRT) ? (src_reg << 2) : (src_reg << 1);
        end
    end

    assign status.busy = busy_reg;
    assign status.done = done_reg;
    assign res         = res_reg;

    a_no_restart: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.start |-> !busy_reg)
        else $error("iterative unit restarted while busy");
    a_done_after_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(busy_reg))
        else $error("completion without a running operation");
    a_cnt_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (busy_reg && !cmd.start) |-> (cnt_reg != '0))
        else $error("step counter exhausted while busy");

endmodule
